>>> sv/dsefr_pkg.sv
package dsefr_pkg;

    // Default buffer depth in bytes
    localparam int BUF_DEPTH_DEF = 512;

    // Stream widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 9;
    localparam int COUNT_W = 10;

    // Framing characters
    localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] CH_DLE = 8'h10;

    // Request kinds
    typedef enum logic [IN_USER_W-1:0] {
        REQ_BYTE    = 2'd0,
        REQ_READ    = 2'd1,
        REQ_TAKE    = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    // Classified request handed from front to back
    typedef struct packed {
        req_t               req;
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               is_stx;
        logic               is_etx;
        logic               is_dle;
        logic               idx_ok;
    } cmd_t;

endpackage

>>> sv/dsefr_front.sv
module dsefr_front #(
    parameter int BUF_DEPTH = dsefr_pkg::BUF_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] rx_byte, [16:8] read_index, [23:17] zero
    input  logic [dsefr_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [dsefr_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                             q_valid,
    input  logic                             q_ready,
    output dsefr_pkg::cmd_t                  q_cmd
);
    import dsefr_pkg::*;

    cmd_t       cmd_in;
    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    // Classify the incoming beat
    always_comb
    begin
        cmd_in.req    = req_t'(s_tuser);
        cmd_in.data   = s_tdata[BYTE_W-1:0];
        cmd_in.index  = s_tdata[BYTE_W+INDEX_W-1:BYTE_W];
        cmd_in.is_stx = (cmd_in.data == CH_STX);
        cmd_in.is_etx = (cmd_in.data == CH_ETX);
        cmd_in.is_dle = (cmd_in.data == CH_DLE);
        cmd_in.idx_ok = (32'(cmd_in.index) < 32'(BUF_DEPTH));
    end

    // Two-entry queue toward the back end
    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> sv/dsefr_back.sv
module dsefr_back #(
    parameter int BUF_DEPTH = dsefr_pkg::BUF_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_data,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  dsefr_pkg::cmd_t                  q_cmd,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] read_data, [17:8] byte_count, [18] frame_ready,
    // [28:19] taken_length, [29] in_frame, [31:30] zero
    output logic [dsefr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dsefr_pkg::*;

    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);

    // Byte buffer
    logic [BYTE_W-1:0] mem [BUF_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_re;
    logic [ADDR_W+INDEX_W-1:0] idx_wide;

    // Receiver state
    logic             raw_mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             complete_reg;
    logic             complete_next;
    logic             esc_reg;
    logic             esc_next;
    logic             open_reg;
    logic             open_next;
    logic [CNT_W-1:0] taken;
    logic             append;
    logic             has_room;
    logic             pop;

    // Result register
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             res_rd_sel_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic             res_ready_reg;
    logic [COUNT_W-1:0] res_taken_reg;
    logic             res_open_reg;
    logic [CNT_W+COUNT_W-1:0] count_wide;
    logic [CNT_W+COUNT_W-1:0] taken_wide;

    // Issue when the result register is free or draining
    assign q_ready  = !res_valid_reg || m_tready;
    assign pop      = q_valid && q_ready;
    assign has_room = (count_reg < CNT_W'(BUF_DEPTH));

    // Request execution
    always_comb
    begin
        count_next    = count_reg;
        complete_next = complete_reg;
        esc_next      = esc_reg;
        open_next     = open_reg;
        taken         = '0;
        append        = 1'b0;
        unique case (q_cmd.req)
            REQ_BYTE:
            begin
                if (raw_mode_reg)
                begin
                    append = 1'b1;
                end
                else if (complete_reg)
                begin
                    open_next = 1'b0;
                end
                else if (q_cmd.is_stx && !esc_reg)
                begin
                    open_next  = 1'b1;
                    count_next = '0;
                end
                else if (q_cmd.is_etx && !esc_reg && open_reg)
                begin
                    open_next     = 1'b0;
                    esc_next      = 1'b0;
                    complete_next = 1'b1;
                end
                else if (q_cmd.is_dle && !esc_reg)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next = 1'b0;
                    append   = open_reg;
                end
                if (append && has_room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_READ:
            begin
            end
            REQ_TAKE:
            begin
                if (complete_reg)
                begin
                    taken         = count_reg;
                    count_next    = '0;
                    complete_next = 1'b0;
                end
            end
            REQ_RESTART:
            begin
                count_next    = '0;
                complete_next = 1'b0;
                esc_next      = 1'b0;
                open_next     = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Buffer port control
    assign mem_we   = pop && append && has_room;
    assign wr_addr  = count_reg[ADDR_W-1:0];
    assign idx_wide = {{ADDR_W{1'b0}}, q_cmd.index};
    assign rd_addr  = idx_wide[ADDR_W-1:0];
    assign mem_re   = pop && (q_cmd.req == REQ_READ) && q_cmd.idx_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= q_cmd.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state
    assign res_valid_next = pop ? 1'b1 : (res_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg  <= 1'b0;
            count_reg     <= '0;
            complete_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            open_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                raw_mode_reg <= cfg_data;
            end
            if (pop)
            begin
                count_reg    <= count_next;
                complete_reg <= complete_next;
                esc_reg      <= esc_next;
                open_reg     <= open_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    assign count_wide = {{COUNT_W{1'b0}}, count_next};
    assign taken_wide = {{COUNT_W{1'b0}}, taken};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_rd_sel_reg <= mem_re;
            res_count_reg  <= count_wide[COUNT_W-1:0];
            res_ready_reg  <= complete_next;
            res_taken_reg  <= taken_wide[COUNT_W-1:0];
            res_open_reg   <= open_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {2'b00, res_open_reg, res_taken_reg, res_ready_reg, res_count_reg,
                       (res_rd_sel_reg ? rd_data_reg : {BYTE_W{1'b0}})};

endmodule

>>> sv/dle_stx_etx_frame_receiver.sv
// Path: an accepted request beat is stored in the two-entry front queue, executed when it
// leaves the queue, and its result beat is held in the result register.
// Throughput: one request per cycle while m_tready does not stall the result channel, set by
// the execute step and the byte buffer, which each request uses for at most one write or read.
// Reset: rst_n is asynchronous, active low; it clears the count, the framing
// flags, the mode register and both queues. Buffer contents are undefined until written.
module dle_stx_etx_frame_receiver #(
    parameter int BUF_DEPTH = dsefr_pkg::BUF_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] rx_byte, [16:8] read_index, [23:17] zero
    input  logic [dsefr_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [dsefr_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] read_data, [17:8] byte_count, [18] frame_ready,
    // [28:19] taken_length, [29] in_frame, [31:30] zero
    output logic [dsefr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dsefr_pkg::*;

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // Mode register is always writable
    assign cfg_ready = 1'b1;

    dsefr_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    dsefr_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> test/frame_rx_monitor.sv
// Watches the config, request and result channels, keeps a shadow of the
// deframer state and compares each result beat with the oldest prediction.
module frame_rx_monitor #(
    parameter int BUF_DEPTH = dsefr_pkg::BUF_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic                             cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [dsefr_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [dsefr_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [dsefr_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                               fail_count,
    output int                               pending,
    output int                               written_span
);
    timeunit 1ns;
    timeprecision 1ps;

    import dsefr_pkg::*;

    // Result beat layout, MSB first
    typedef struct packed {
        logic [1:0]         pad;
        logic               in_frame;
        logic [COUNT_W-1:0] taken_length;
        logic               frame_ready;
        logic [COUNT_W-1:0] byte_count;
        logic [BYTE_W-1:0]  read_data;
    } rx_status_t;

    // Shadow state
    logic [BYTE_W-1:0] rx_buf [BUF_DEPTH];
    int                fill_level;
    int                fill_peak;
    bit                frame_done;
    bit                dle_armed;
    bit                frame_live;
    bit                raw_on;
    int                errors = 0;
    rx_status_t        due_results [$];

    // Append one byte; silently dropped once the buffer is full
    function automatic void store_byte(logic [BYTE_W-1:0] b);
        if (fill_level < BUF_DEPTH)
        begin
            rx_buf[fill_level] = b;
            fill_level++;
            if (fill_level > fill_peak)
                fill_peak = fill_level;
        end
    endfunction

    // Apply one request beat to the shadow state, return the expected status
    function automatic rx_status_t deframe_step(req_t req, logic [BYTE_W-1:0] b,
                                                logic [INDEX_W-1:0] idx);
        rx_status_t st;
        st = '0;
        case (req)
            REQ_BYTE:
            begin
                if (raw_on)
                    store_byte(b);
                else if (frame_done)
                    frame_live = 1'b0;
                else if (b == CH_STX && !dle_armed)
                begin
                    frame_live = 1'b1;
                    fill_level = 0;
                end
                else if (b == CH_ETX && !dle_armed && frame_live)
                begin
                    frame_live = 1'b0;
                    dle_armed  = 1'b0;
                    frame_done = 1'b1;
                end
                else if (b == CH_DLE && !dle_armed)
                    dle_armed = 1'b1;
                else
                begin
                    dle_armed = 1'b0;
                    if (frame_live)
                        store_byte(b);
                end
            end
            REQ_READ:
            begin
                if (idx < BUF_DEPTH)
                    st.read_data = rx_buf[idx];
            end
            REQ_TAKE:
            begin
                if (frame_done)
                begin
                    st.taken_length = COUNT_W'(fill_level);
                    fill_level      = 0;
                    frame_done      = 1'b0;
                end
            end
            default:
            begin
                fill_level = 0;
                frame_done = 1'b0;
                dle_armed  = 1'b0;
                frame_live = 1'b0;
            end
        endcase
        st.byte_count  = COUNT_W'(fill_level);
        st.frame_ready = frame_done;
        st.in_frame    = frame_live;
        return st;
    endfunction

    // Compare one result beat against the oldest prediction
    task automatic check_result(rx_status_t got);
        rx_status_t want;
        if (due_results.size() == 0)
        begin
            $error("result beat with no request outstanding: %h", got);
            errors++;
        end
        else
        begin
            want = due_results.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
                errors++;
            end
            if (got.byte_count !== want.byte_count)
            begin
                $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
                errors++;
            end
            if (got.frame_ready !== want.frame_ready)
            begin
                $error("frame_ready: expected %0d, got %0d",
                       want.frame_ready, got.frame_ready);
                errors++;
            end
            if (got.taken_length !== want.taken_length)
            begin
                $error("taken_length: expected %0d, got %0d",
                       want.taken_length, got.taken_length);
                errors++;
            end
            if (got.in_frame !== want.in_frame)
            begin
                $error("in_frame: expected %0d, got %0d", want.in_frame, got.in_frame);
                errors++;
            end
        end
    endtask

    // Predict on request beats, check on result beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_level = 0;
            fill_peak  = 0;
            frame_done = 1'b0;
            dle_armed  = 1'b0;
            frame_live = 1'b0;
            raw_on     = 1'b0;
            due_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                raw_on = cfg_data;
            if (s_tvalid && s_tready)
                due_results.push_back(deframe_step(req_t'(s_tuser), s_tdata[7:0],
                                                   s_tdata[16:8]));
            if (m_tvalid && m_tready)
                check_result(rx_status_t'(m_tdata));
        end
        pending      <= due_results.size();
        written_span <= fill_peak;
        fail_count   <= errors;
    end

endmodule

>>> test/tb_dle_stx_etx_frame_receiver.sv
module tb_dle_stx_etx_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import dsefr_pkg::*;

    // Cycles with no beat on any channel before the run is called hung
    localparam int STALL_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // [7:0] rx_byte, [16:8] read_index, [23:17] zero
    logic [IN_DATA_W-1:0]  s_tdata;
    // [1:0] req_type
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [7:0] read_data, [17:8] byte_count, [18] frame_ready,
    // [28:19] taken_length, [29] in_frame, [31:30] zero
    logic [OUT_DATA_W-1:0] m_tdata;

    int send_gap_pct = 9;
    int recv_gap_pct = 60;
    int beats_sent   = 0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;
    int written_span;

    dle_stx_etx_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    frame_rx_monitor monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .written_span (written_span)
    );

    always #1 clk = ~clk;

    // Result-side backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Hang detection
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[dle_stx_etx_frame_receiver] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one request beat, with an optional gap ahead of it
    task automatic push_req(req_t req, logic [BYTE_W-1:0] b, logic [INDEX_W-1:0] idx);
        bit hit;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'b0, idx, b};
        hit = 1'b0;
        while (!hit)
        begin
            @(negedge clk);
            hit = s_tready;
            @(posedge clk);
        end
        beats_sent++;
    endtask

    // Random byte leaning toward the framing characters and the extremes
    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(9))
            0:       return CH_STX;
            1:       return CH_ETX;
            2:       return CH_DLE;
            3:       return 8'h00;
            4:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic send_byte(logic [BYTE_W-1:0] b);
        push_req(REQ_BYTE, b, INDEX_W'($urandom));
    endtask

    task automatic send_ctl(req_t req);
        push_req(req, BYTE_W'($urandom), INDEX_W'($urandom));
    endtask

    // Read only entries that have been written at some point
    task automatic send_read();
        int idx;
        if (written_span == 0)
            send_ctl(REQ_TAKE);
        else
        begin
            idx = ($urandom_range(3) == 0) ? written_span - 1
                                           : $urandom_range(written_span - 1);
            push_req(REQ_READ, BYTE_W'($urandom), INDEX_W'(idx));
        end
    endtask

    // Wait until every request has its result back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mode write, only with the block drained
    task automatic send_cfg(bit raw);
        bit hit;
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= raw;
        hit = 1'b0;
        while (!hit)
        begin
            @(negedge clk);
            hit = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // STX, escaped payload, optional ETX
    task automatic send_frame(int len, bit closed);
        logic [BYTE_W-1:0] b;
        send_byte(CH_STX);
        for (int i = 0; i < len; i++)
        begin
            b = rand_byte();
            if (b == CH_STX || b == CH_ETX || b == CH_DLE || $urandom_range(9) == 0)
                send_byte(CH_DLE);
            send_byte(b);
        end
        if (closed)
            send_byte(CH_ETX);
    endtask

    // Framed traffic: mostly clean frames, some broken ones and noise
    task automatic framed_traffic(int quota);
        int stop;
        int pick;
        int len;
        stop = beats_sent + quota;
        while (beats_sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                len = ($urandom_range(49) == 0) ? $urandom_range(500, 560)
                                                : $urandom_range(0, 12);
                send_frame(len, 1'b1);
                repeat ($urandom_range(0, 3)) send_read();
                if ($urandom_range(4) == 0)
                    send_byte(rand_byte());
                if ($urandom_range(9) != 0)
                    send_ctl(REQ_TAKE);
            end
            else if (pick < 78)
            begin
                send_frame($urandom_range(0, 6), 1'b0);
                case ($urandom_range(2))
                    0:       send_ctl(REQ_RESTART);
                    1:       send_byte(CH_STX);
                    default: ;
                endcase
            end
            else if (pick < 90)
                send_byte(rand_byte());
            else
            begin
                case ($urandom_range(2))
                    0:       send_read();
                    1:       send_ctl(REQ_TAKE);
                    default: send_ctl(REQ_RESTART);
                endcase
            end
        end
    endtask

    // Raw traffic: mostly bytes with reads mixed in
    task automatic raw_traffic(int quota);
        int stop;
        int pick;
        stop = beats_sent + quota;
        while (beats_sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_byte(rand_byte());
            else if (pick < 94)
                send_read();
            else if (pick < 98)
                send_ctl(REQ_TAKE);
            else
                send_ctl(REQ_RESTART);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_BYTE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: framed mode
        send_cfg(1'b0);
        send_byte(CH_STX);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_DLE);
        send_byte(CH_STX);          // escaped STX is data
        send_byte(CH_DLE);
        send_byte(CH_ETX);          // escaped ETX is data
        send_byte(CH_DLE);
        send_byte(CH_DLE);          // escaped DLE is data
        send_byte(CH_ETX);          // frame complete
        send_byte(8'h41);           // ignored while frame waits
        push_req(REQ_READ, 8'h00, 9'd0);
        push_req(REQ_READ, 8'hFF, 9'd4);
        send_ctl(REQ_TAKE);
        send_ctl(REQ_TAKE);         // nothing left to take
        send_byte(CH_ETX);          // ETX outside a frame
        send_byte(CH_STX);
        send_byte(8'h55);
        send_byte(CH_STX);          // restarts the open frame
        send_byte(8'h66);
        send_ctl(REQ_RESTART);
        send_byte(CH_DLE);
        send_byte(CH_ETX);          // escaped byte outside a frame
        send_frame(1, 1'b1);        // leave a frame waiting for raw mode

        // Directed: raw mode
        send_cfg(1'b1);
        send_ctl(REQ_TAKE);         // take of frame completed in framed mode
        send_ctl(REQ_TAKE);
        send_byte(CH_STX);
        send_byte(CH_DLE);
        send_byte(CH_ETX);
        push_req(REQ_READ, 8'h00, 9'd2);
        send_ctl(REQ_RESTART);

        // Random phases under three backpressure profiles
        for (int profile = 0; profile < 3; profile++)
        begin
            case (profile)
                0:
                begin
                    send_gap_pct = 9;
                    recv_gap_pct = 60;
                end
                1:
                begin
                    send_gap_pct = 60;
                    recv_gap_pct = 9;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            send_cfg(1'b0);
            framed_traffic(270);
            send_cfg(1'b1);
            if (profile == 0)
            begin
                // run the buffer past full so every entry gets written
                send_ctl(REQ_RESTART);
                for (int i = 0; i < 620; i++)
                begin
                    if ($urandom_range(9) == 0)
                        send_read();
                    else
                        send_byte(rand_byte());
                end
            end
            raw_traffic(150);
        end

        // Drain and verdict
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[dle_stx_etx_frame_receiver] OK");
        else
            $display("[dle_stx_etx_frame_receiver] ERROR");
        $finish;
    end

endmodule
